### design/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants of the MIDI track event encoder: beat payloads,
// configuration set, command and register codes, and the event descriptor
// passed from the front end to the byte serialiser.
// ----------------------------------------------------------------------------
package mte_pkg;

  // Variable-length quantity limits
  localparam int MAX_VLQ_BYTES = 4;
  localparam int VLQ_BITS      = 7 * MAX_VLQ_BYTES;
  localparam int VLQ_CNT_W     = $clog2(MAX_VLQ_BYTES + 1);

  // Input commands
  localparam logic [1:0] CMD_BEGIN    = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;
  localparam logic [1:0] CMD_END      = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISIONS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_US         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_VELOCITY = 3'd4;
  localparam int CFG_DATA_W = 24;

  // MIDI status and meta bytes
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_PROGRAM  = 8'hC0;
  localparam logic [7:0] META_PREFIX     = 8'hFF;
  localparam logic [7:0] META_TEMPO      = 8'h51;
  localparam logic [7:0] META_END_TRACK  = 8'h2F;

  typedef struct packed {
    logic [1:0]  command;
    logic [30:0] step_time;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [23:0] event_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] track_bytes;
    logic        size_mismatch;
  } out_item_t;

  typedef struct packed {
    logic [15:0] divisions;
    logic [23:0] tempo_us;
    logic [3:0]  channel;
    logic [6:0]  program_cfg;
    logic [6:0]  release_velocity;
  } cfg_t;

  // One classified event, ready for serialising
  typedef struct packed {
    logic [1:0]           command;
    logic [4:0]           last_idx;
    logic [VLQ_CNT_W-1:0] vlq_n;
    logic [VLQ_BITS-1:0]  delta;
    logic [7:0]           status;
    logic [6:0]           note;
    logic [6:0]           vel;
    logic [31:0]          est_len;
    logic [31:0]          track_bytes;
    logic                 size_mismatch;
  } desc_t;

endpackage

### design/mte_front.sv
// ----------------------------------------------------------------------------
// mte_front
// Front end: holds the configuration registers and the track state, accepts
// input beats and turns each into an event descriptor with its byte count,
// delta time, status byte and running track byte count.
// ----------------------------------------------------------------------------
module mte_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mte_pkg::in_item_t                  in_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mte_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mte_pkg::cfg_t                      cfg,
  output logic                               desc_valid,
  input  logic                               desc_ready,
  output mte_pkg::desc_t                     desc
);

  localparam logic [30:0] VLQ_LIMIT = 31'((64'd1 << mte_pkg::VLQ_BITS) - 64'd1);

  logic [30:0] prev_step;
  logic        first_pending;
  logic [31:0] data_cnt;
  logic [31:0] est_len;

  logic [30:0] prev_step_next;
  logic        first_pending_next;
  logic [31:0] data_cnt_next;
  logic [31:0] est_len_next;

  logic [30:0]                      delta_raw;
  logic [mte_pkg::VLQ_BITS-1:0]     delta;
  logic [mte_pkg::VLQ_CNT_W-1:0]    vlq_n;
  logic                             accept;

  assign cfg_ready  = 1'b1;
  assign in_ready   = desc_ready;
  assign desc_valid = in_valid;
  assign accept     = in_valid && desc_ready;

  // Clamp negative deltas to zero, saturate large ones
  always_comb begin
    if (!first_pending && (in_item.step_time > prev_step)) begin
      delta_raw = in_item.step_time - prev_step;
    end else begin
      delta_raw = '0;
    end
    if (delta_raw > VLQ_LIMIT) begin
      delta = mte_pkg::VLQ_BITS'(VLQ_LIMIT);
    end else begin
      delta = mte_pkg::VLQ_BITS'(delta_raw);
    end
  end

  // Count the seven-bit groups needed for the delta
  always_comb begin
    vlq_n = mte_pkg::VLQ_CNT_W'(1);
    for (int j = 1; j < mte_pkg::MAX_VLQ_BYTES; j++) begin
      if ((delta >> (7 * j)) != '0) begin
        vlq_n = mte_pkg::VLQ_CNT_W'(j + 1);
      end
    end
  end

  // Classify the beat and work out the next track state
  always_comb begin
    prev_step_next     = prev_step;
    first_pending_next = first_pending;
    data_cnt_next      = data_cnt;
    est_len_next       = est_len;

    desc               = '0;
    desc.command       = in_item.command;
    desc.vlq_n         = vlq_n;
    desc.delta         = delta;
    desc.note          = in_item.note;

    unique case (in_item.command)
      mte_pkg::CMD_BEGIN: begin
        est_len_next       = 32'd7 + {6'd0, in_item.event_count, 2'b00};
        data_cnt_next      = 32'd10;
        prev_step_next     = '0;
        first_pending_next = 1'b1;
        desc.last_idx      = 5'd31;
      end
      mte_pkg::CMD_NOTE_ON, mte_pkg::CMD_NOTE_OFF: begin
        prev_step_next     = in_item.step_time;
        first_pending_next = 1'b0;
        data_cnt_next      = data_cnt + 32'(vlq_n) + 32'd3;
        desc.last_idx      = 5'(vlq_n) + 5'd2;
        if (in_item.command == mte_pkg::CMD_NOTE_ON) begin
          desc.status = mte_pkg::STATUS_NOTE_ON | {4'd0, cfg.channel};
          desc.vel    = in_item.velocity;
        end else begin
          desc.status = mte_pkg::STATUS_NOTE_OFF | {4'd0, cfg.channel};
          desc.vel    = cfg.release_velocity;
        end
      end
      default: begin
        data_cnt_next      = data_cnt + 32'd4;
        desc.last_idx      = 5'd3;
        desc.size_mismatch = (data_cnt_next != est_len);
      end
    endcase

    desc.est_len     = est_len_next;
    desc.track_bytes = data_cnt_next;
  end

  // Hold track state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_step     <= '0;
      first_pending <= 1'b1;
      data_cnt      <= '0;
      est_len       <= '0;
    end else if (accept) begin
      prev_step     <= prev_step_next;
      first_pending <= first_pending_next;
      data_cnt      <= data_cnt_next;
      est_len       <= est_len_next;
    end
  end

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.divisions        <= 16'd96;
      cfg.tempo_us         <= 24'd500000;
      cfg.channel          <= 4'd0;
      cfg.program_cfg      <= 7'd0;
      cfg.release_velocity <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mte_pkg::CFG_DIVISIONS:        cfg.divisions        <= cfg_data[15:0];
        mte_pkg::CFG_TEMPO_US:         cfg.tempo_us         <= cfg_data[23:0];
        mte_pkg::CFG_CHANNEL:          cfg.channel          <= cfg_data[3:0];
        mte_pkg::CFG_PROGRAM:          cfg.program_cfg      <= cfg_data[6:0];
        mte_pkg::CFG_RELEASE_VELOCITY: cfg.release_velocity <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

### design/mte_queue.sv
// ----------------------------------------------------------------------------
// mte_queue
// Short first-in first-out queue of event descriptors between the front end
// and the byte serialiser.
// ----------------------------------------------------------------------------
module mte_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  mte_pkg::desc_t wr_data,
  output logic           rd_valid,
  input  logic           rd_pop,
  output mte_pkg::desc_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mte_pkg::desc_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_data  = slots[rd_ptr];

  // Store incoming descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/mte_back.sv
// ----------------------------------------------------------------------------
// mte_back
// Byte serialiser: walks one descriptor into the output register a byte per
// cycle unless stalled by out_ready, and pops the descriptor on its last byte.
// ----------------------------------------------------------------------------
module mte_back (
  input  logic               clk,
  input  logic               rst,
  input  mte_pkg::cfg_t      cfg,
  input  logic               desc_valid,
  output logic               desc_pop,
  input  mte_pkg::desc_t     desc,
  output logic               out_valid,
  input  logic               out_ready,
  output mte_pkg::out_item_t out_item
);

  logic [4:0]                    idx;
  logic                          load;
  logic                          is_last;
  logic [7:0]                    byte_val;
  logic [4:0]                    rel;
  logic [mte_pkg::VLQ_CNT_W-1:0] vlq_sel;
  logic [6:0]                    grp;

  // Header, track header, tempo and program change of a begin event
  function automatic logic [7:0] begin_byte(input logic [4:0] i, input mte_pkg::cfg_t c,
                                            input logic [31:0] est);
    logic [7:0] b;
    unique case (i)
      5'd0:    b = 8'h4D;
      5'd1:    b = 8'h54;
      5'd2:    b = 8'h68;
      5'd3:    b = 8'h64;
      5'd7:    b = 8'h06;
      5'd11:   b = 8'h01;
      5'd12:   b = c.divisions[15:8];
      5'd13:   b = c.divisions[7:0];
      5'd14:   b = 8'h4D;
      5'd15:   b = 8'h54;
      5'd16:   b = 8'h72;
      5'd17:   b = 8'h6B;
      5'd18:   b = est[31:24];
      5'd19:   b = est[23:16];
      5'd20:   b = est[15:8];
      5'd21:   b = est[7:0];
      5'd23:   b = mte_pkg::META_PREFIX;
      5'd24:   b = mte_pkg::META_TEMPO;
      5'd25:   b = 8'h03;
      5'd26:   b = c.tempo_us[23:16];
      5'd27:   b = c.tempo_us[15:8];
      5'd28:   b = c.tempo_us[7:0];
      5'd30:   b = mte_pkg::STATUS_PROGRAM | {4'd0, c.channel};
      5'd31:   b = {1'b0, c.program_cfg};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign load     = desc_valid && (!out_valid || out_ready);
  assign is_last  = (idx == desc.last_idx);
  assign desc_pop = load && is_last;
  assign rel      = idx - 5'(desc.vlq_n);
  assign vlq_sel  = mte_pkg::VLQ_CNT_W'(5'(desc.vlq_n) - 5'd1 - idx);

  // Pick the delta group for the current position, most significant first
  always_comb begin
    grp = '0;
    for (int j = 0; j < mte_pkg::MAX_VLQ_BYTES; j++) begin
      if (vlq_sel == mte_pkg::VLQ_CNT_W'(j)) begin
        grp = desc.delta[7*j +: 7];
      end
    end
  end

  // Select the byte for the current position
  always_comb begin
    unique case (desc.command)
      mte_pkg::CMD_BEGIN: begin
        byte_val = begin_byte(idx, cfg, desc.est_len);
      end
      mte_pkg::CMD_NOTE_ON, mte_pkg::CMD_NOTE_OFF: begin
        if (idx < 5'(desc.vlq_n)) begin
          byte_val = {(vlq_sel != '0), grp};
        end else begin
          unique case (rel[1:0])
            2'd0:    byte_val = desc.status;
            2'd1:    byte_val = {1'b0, desc.note};
            default: byte_val = {1'b0, desc.vel};
          endcase
        end
      end
      default: begin
        unique case (idx[1:0])
          2'd1:    byte_val = mte_pkg::META_PREFIX;
          2'd2:    byte_val = mte_pkg::META_END_TRACK;
          default: byte_val = 8'h00;
        endcase
      end
    endcase
  end

  // Advance position and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 5'd0 : idx + 5'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_byte      <= byte_val;
      out_item.last          <= is_last;
      out_item.track_bytes   <= desc.track_bytes;
      out_item.size_mismatch <= desc.size_mismatch;
    end
  end

endmodule

### design/midi_track_event_encoder_top.sv
// ----------------------------------------------------------------------------
// midi_track_event_encoder_top
// Turns timed note events into Standard MIDI File bytes, one byte per beat.
//
// Input channel (in_valid/in_ready/in_item): begin, note-on, note-off and
// end commands. Output channel (out_valid/out_ready/out_item): file bytes,
// last marks the final byte of each input, track_bytes the running count.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; write only while no bytes are outstanding.
// An item waits in the queue; its bytes then leave through the output register.
// Throughput: one byte per cycle from the serialiser while out_ready is high;
// a note is 4 to 7 bytes (1 to 4 delta bytes plus 3), begin 32 and end 4.
// Up to QUEUE_DEPTH classified items wait in the queue, so the front end
// keeps taking items while the serialiser works.
// Reset restores the configuration defaults, empties the queue and clears
// the track state. A stalled receiver holds the output beat; the queue then
// fills and in_ready drops.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mte_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mte_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mte_pkg::CFG_DATA_W-1:0] cfg_data
);

  mte_pkg::cfg_t  cfg;
  mte_pkg::desc_t front_desc;
  mte_pkg::desc_t back_desc;
  logic           front_valid;
  logic           queue_ready;
  logic           back_valid;
  logic           back_pop;

  mte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .desc_valid (front_valid),
    .desc_ready (queue_ready),
    .desc       (front_desc)
  );

  mte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (queue_ready),
    .wr_data  (front_desc),
    .rd_valid (back_valid),
    .rd_pop   (back_pop),
    .rd_data  (back_desc)
  );

  mte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .desc_valid (back_valid),
    .desc_pop   (back_pop),
    .desc       (back_desc),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

### design/mte_checker.sv
// ----------------------------------------------------------------------------
// mte_checker
// Port-level checks of the MIDI track event encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mte_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input mte_pkg::out_item_t out_item
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output beat changed while stalled");

  // Nothing is shown straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Bytes of one item follow without a gap and share the track count
  a_item_contiguous: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.last |=>
      out_valid && (out_item.track_bytes == $past(out_item.track_bytes)))
    else $error("item bytes broken up or track count changed");

  // The mismatch flag only rides on end-of-track bytes
  a_mismatch_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.size_mismatch |->
      (out_item.out_byte == 8'h00) || (out_item.out_byte == mte_pkg::META_PREFIX) ||
      (out_item.out_byte == mte_pkg::META_END_TRACK))
    else $error("mismatch flag outside end-of-track event");

endmodule

bind midi_track_event_encoder_top mte_checker u_mte_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

### bench/midi_track_event_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// midi_track_event_encoder_top_tb
// Self-checking bench for the MIDI track event encoder. A short stimulus
// table covers reset state, repeated ends, a clean size match, every length
// of delta encoding, clamping and saturation. Randomised tracks and noise
// follow over several register settings. Every byte beat is compared with a
// local encoder model, with random idling on both channels and a long
// receiver stall that fills the queue.
// ----------------------------------------------------------------------------
module midi_track_event_encoder_top_tb;

  localparam int IDLE_PCT     = 29;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE_CYC   = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int N_DIR        = 24;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 48;
  localparam int HOLD_PHASE   = 2;
  localparam int FREE_PHASE   = 3;

  // Chunk identifiers and fixed header fields
  localparam logic [31:0] MTHD_ID      = "MThd";
  localparam logic [31:0] MTRK_ID      = "MTrk";
  localparam logic [31:0] MTHD_LEN     = 32'd6;
  localparam logic [15:0] SMF_FORMAT   = 16'd0;
  localparam logic [15:0] SMF_TRACKS   = 16'd1;
  localparam logic [7:0]  TEMPO_LEN    = 8'h03;
  localparam logic [31:0] LEN_BASE     = 32'd7;
  localparam logic [31:0] PREAMBLE_CNT = 32'd10;
  localparam logic [31:0] VLQ_MAX      = (32'd1 << mte_pkg::VLQ_BITS) - 32'd1;

  typedef struct packed {
    logic        typed;
    logic [31:0] track;
    logic        mism;
  } table_check_t;

  typedef struct packed {
    mte_pkg::in_item_t item;
    table_check_t      chk;
  } stim_row_t;

  localparam table_check_t NO_CHECK = '0;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  mte_pkg::in_item_t              in_item;
  logic                           out_valid;
  logic                           out_ready;
  mte_pkg::out_item_t             out_item;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mte_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mte_pkg::CFG_DATA_W-1:0] cfg_data;

  // Model state: register copy and track state
  mte_pkg::cfg_t model_cfg = '{divisions: 16'd96, tempo_us: 24'd500000, channel: 4'd0,
                               program_cfg: 7'd0, release_velocity: 7'd64};
  logic [31:0] prev_step     = '0;
  logic        first_pending = 1'b1;
  logic [31:0] byte_count    = '0;
  logic [31:0] est_length    = '0;

  mte_pkg::out_item_t pending_bytes [$];
  table_check_t       item_tags [$];
  table_check_t       cur_tag   = NO_CHECK;

  int   error_count = 0;
  int   items_sent  = 0;
  int   cycle_count = 0;
  logic src_free    = 1'b0;
  logic sink_free   = 1'b0;
  logic stall_req   = 1'b0;

  midi_track_event_encoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Number of bytes a delta takes as a variable-length quantity
  function automatic int vlq_len(input logic [31:0] delta);
    int n;
    n = 1;
    while (n < mte_pkg::MAX_VLQ_BYTES && (delta >> (7 * n)) != 0) n++;
    return n;
  endfunction

  function automatic mte_pkg::in_item_t random_item();
    mte_pkg::in_item_t it;
    it.command     = 2'($urandom_range(0, 3));
    it.step_time   = 31'($urandom);
    it.note        = 7'($urandom);
    it.velocity    = 7'($urandom);
    it.event_count = 24'($urandom);
    return it;
  endfunction

  function automatic stim_row_t row_of(input logic [1:0] cmd, input logic [30:0] st,
                                       input logic [6:0] nt, input logic [6:0] vel,
                                       input logic [23:0] cnt, input logic typed,
                                       input logic [31:0] trk, input logic mm);
    stim_row_t r;
    r.item = '{command: cmd, step_time: st, note: nt, velocity: vel, event_count: cnt};
    r.chk  = '{typed: typed, track: trk, mism: mm};
    return r;
  endfunction

  // Encode one accepted item into its file bytes and queue them
  task automatic encode_event(input mte_pkg::in_item_t it);
    logic [7:0]         seq [$];
    logic [255:0]       preamble;
    logic [31:0]        delta;
    logic [7:0]         status;
    logic               mism;
    mte_pkg::out_item_t ob;
    int                 n;
    int                 i;
    mism = 1'b0;
    case (it.command)
      mte_pkg::CMD_BEGIN: begin
        est_length = LEN_BASE + 32'd4 * {8'd0, it.event_count};
        preamble = {MTHD_ID, MTHD_LEN, SMF_FORMAT, SMF_TRACKS, model_cfg.divisions,
                    MTRK_ID, est_length, 8'h00, mte_pkg::META_PREFIX, mte_pkg::META_TEMPO,
                    TEMPO_LEN, model_cfg.tempo_us, 8'h00,
                    mte_pkg::STATUS_PROGRAM | {4'h0, model_cfg.channel},
                    {1'b0, model_cfg.program_cfg}};
        for (i = 31; i >= 0; i--) seq.push_back(preamble[8 * i +: 8]);
        prev_step     = '0;
        first_pending = 1'b1;
        byte_count    = PREAMBLE_CNT;
      end
      mte_pkg::CMD_NOTE_ON, mte_pkg::CMD_NOTE_OFF: begin
        // Clamp backward steps to zero, saturate long gaps
        delta = '0;
        if (!first_pending && {1'b0, it.step_time} > prev_step)
          delta = {1'b0, it.step_time} - prev_step;
        if (delta > VLQ_MAX) delta = VLQ_MAX;
        prev_step     = {1'b0, it.step_time};
        first_pending = 1'b0;
        n = vlq_len(delta);
        for (i = n - 1; i >= 0; i--) seq.push_back({i > 0, delta[7 * i +: 7]});
        status = (it.command == mte_pkg::CMD_NOTE_ON) ? mte_pkg::STATUS_NOTE_ON
                                                      : mte_pkg::STATUS_NOTE_OFF;
        seq.push_back(status | {4'h0, model_cfg.channel});
        seq.push_back({1'b0, it.note});
        if (it.command == mte_pkg::CMD_NOTE_ON) seq.push_back({1'b0, it.velocity});
        else seq.push_back({1'b0, model_cfg.release_velocity});
        byte_count = byte_count + 32'(seq.size());
      end
      mte_pkg::CMD_END: begin
        seq.push_back(8'h00);
        seq.push_back(mte_pkg::META_PREFIX);
        seq.push_back(mte_pkg::META_END_TRACK);
        seq.push_back(8'h00);
        byte_count = byte_count + 32'd4;
        mism = (byte_count != est_length);
      end
    endcase
    for (i = 0; i < seq.size(); i++) begin
      ob.out_byte      = seq[i];
      ob.last          = (i == seq.size() - 1);
      ob.track_bytes   = byte_count;
      ob.size_mismatch = mism;
      pending_bytes.push_back(ob);
    end
  endtask

  // Offer one item, idling first at random; leaves valid high on return
  task automatic send_item(input mte_pkg::in_item_t it, input table_check_t tg);
    while (!src_free && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_item  = it;
    cur_tag  = tg;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [mte_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mte_pkg::CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold the input and wait until every expected byte has come out
  task automatic drain_output();
    in_valid = 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // One well-formed track with random content, now and then broken
  task automatic play_track();
    logic [31:0]       steps [$];
    logic [31:0]       t;
    logic [31:0]       nxt;
    logic [31:0]       dv;
    logic [23:0]       cnt;
    mte_pkg::in_item_t it;
    int                nnotes;
    int                total;
    int                k;
    nnotes = $urandom_range(0, 10);
    t = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h7FFFFFFF) : $urandom_range(0, 4095);
    for (k = 0; k < nnotes; k++) begin
      case ($urandom_range(0, 9))
        0:          nxt = t;
        1, 2, 3, 4: nxt = t + $urandom_range(1, 127);
        5, 6:       nxt = t + $urandom_range(128, 16383);
        7:          nxt = t + $urandom_range(16384, 2097151);
        8:          nxt = t + $urandom_range(2097152, 268435455);
        default:    nxt = $urandom_range(0, 1) ? t + $urandom_range(268435456, 1073741824)
                                               : $urandom_range(0, t);
      endcase
      if (nxt > 32'h7FFFFFFF) nxt = $urandom_range(0, 1023);
      steps.push_back(nxt);
      t = nxt;
    end
    // Track byte total, to pick a count that matches now and then
    total = 0;
    for (k = 0; k < nnotes; k++) begin
      dv = (k > 0 && steps[k] > steps[k-1]) ? steps[k] - steps[k-1] : 32'd0;
      if (dv > VLQ_MAX) dv = VLQ_MAX;
      total += vlq_len(dv) + 3;
    end
    if ((total + 7) % 4 == 0 && $urandom_range(0, 1)) cnt = 24'((total + 7) / 4);
    else if ($urandom_range(0, 3) == 0) cnt = 24'($urandom);
    else cnt = 24'(nnotes);
    if ($urandom_range(0, 9) != 0) begin
      it = random_item();
      it.command     = mte_pkg::CMD_BEGIN;
      it.event_count = cnt;
      send_item(it, NO_CHECK);
    end
    for (k = 0; k < nnotes; k++) begin
      it = random_item();
      it.command   = $urandom_range(0, 1) ? mte_pkg::CMD_NOTE_ON : mte_pkg::CMD_NOTE_OFF;
      it.step_time = steps[k][30:0];
      send_item(it, NO_CHECK);
    end
    it = random_item();
    it.command = mte_pkg::CMD_END;
    send_item(it, NO_CHECK);
    if ($urandom_range(0, 7) == 0) send_item(it, NO_CHECK);
  endtask

  // Predict on accepted items, check every output beat
  always @(posedge clk) begin : monitor
    mte_pkg::out_item_t want;
    table_check_t       tag;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mte_pkg::CFG_DIVISIONS:        model_cfg.divisions        = cfg_data[15:0];
          mte_pkg::CFG_TEMPO_US:         model_cfg.tempo_us         = cfg_data[23:0];
          mte_pkg::CFG_CHANNEL:          model_cfg.channel          = cfg_data[3:0];
          mte_pkg::CFG_PROGRAM:          model_cfg.program_cfg      = cfg_data[6:0];
          mte_pkg::CFG_RELEASE_VELOCITY: model_cfg.release_velocity = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        encode_event(in_item);
        item_tags.push_back(cur_tag);
      end
      if (out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected output beat: out_byte %0h", out_item.out_byte);
          error_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_item.out_byte);
            error_count++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_item.last);
            error_count++;
          end
          if (out_item.track_bytes !== want.track_bytes) begin
            $error("track_bytes: expected %0d, got %0d", want.track_bytes,
                   out_item.track_bytes);
            error_count++;
          end
          if (out_item.size_mismatch !== want.size_mismatch) begin
            $error("size_mismatch: expected %0b, got %0b", want.size_mismatch,
                   out_item.size_mismatch);
            error_count++;
          end
          // Final byte of an item: compare against the typed table values
          if (want.last) begin
            tag = item_tags.pop_front();
            if (tag.typed && out_item.track_bytes !== tag.track) begin
              $error("track_bytes: expected %0d, got %0d", tag.track, out_item.track_bytes);
              error_count++;
            end
            if (tag.typed && out_item.size_mismatch !== tag.mism) begin
              $error("size_mismatch: expected %0b, got %0b", tag.mism,
                     out_item.size_mismatch);
              error_count++;
            end
          end
        end
      end
    end
  end

  // Receiver: random idling, or a long hold-off on request
  initial begin : sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stall_req = 1'b0;
      end
      out_ready = sink_free || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t                      dir_rows [N_DIR];
    logic [mte_pkg::CFG_DATA_W-1:0] vals [5];
    int                             r;
    int                             phase;
    int                             quota;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // Reset state, repeated ends, clean match, every delta length, clamping
    dir_rows[0]  = row_of(mte_pkg::CMD_NOTE_ON, 31'd0, 7'd0, 7'd0, 24'd0,
                          1'b1, 32'd4, 1'b0);
    dir_rows[1]  = row_of(mte_pkg::CMD_END, 31'd0, 7'd0, 7'd0, 24'd0,
                          1'b1, 32'd8, 1'b1);
    dir_rows[2]  = row_of(mte_pkg::CMD_END, 31'd0, 7'd0, 7'd0, 24'd0,
                          1'b1, 32'd12, 1'b1);
    dir_rows[3]  = row_of(mte_pkg::CMD_BEGIN, 31'd0, 7'd0, 7'd0, 24'd0,
                          1'b1, 32'd10, 1'b0);
    dir_rows[4]  = row_of(mte_pkg::CMD_NOTE_ON, 31'd100, 7'd127, 7'd127, 24'd0,
                          1'b1, 32'd14, 1'b0);
    dir_rows[5]  = row_of(mte_pkg::CMD_NOTE_OFF, 31'd300, 7'd60, 7'd127, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[6]  = row_of(mte_pkg::CMD_NOTE_ON, 31'd250, 7'd64, 7'd1, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[7]  = row_of(mte_pkg::CMD_END, 31'd0, 7'd0, 7'd0, 24'd0,
                          1'b1, 32'd27, 1'b1);
    dir_rows[8]  = row_of(mte_pkg::CMD_BEGIN, 31'd0, 7'd0, 7'd0, 24'd4,
                          1'b1, 32'd10, 1'b0);
    dir_rows[9]  = row_of(mte_pkg::CMD_NOTE_ON, 31'd5, 7'd1, 7'd100, 24'd0,
                          1'b1, 32'd14, 1'b0);
    dir_rows[10] = row_of(mte_pkg::CMD_NOTE_OFF, 31'd205, 7'd1, 7'd0, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[11] = row_of(mte_pkg::CMD_END, 31'd0, 7'd0, 7'd0, 24'd0,
                          1'b1, 32'd23, 1'b0);
    dir_rows[12] = row_of(mte_pkg::CMD_BEGIN, 31'h7FFFFFFF, 7'd127, 7'd127, 24'hFFFFFF,
                          1'b1, 32'd10, 1'b0);
    dir_rows[13] = row_of(mte_pkg::CMD_NOTE_ON, 31'd0, 7'd10, 7'd20, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[14] = row_of(mte_pkg::CMD_NOTE_ON, 31'd127, 7'd11, 7'd21, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[15] = row_of(mte_pkg::CMD_NOTE_ON, 31'd255, 7'd12, 7'd22, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[16] = row_of(mte_pkg::CMD_NOTE_OFF, 31'd16638, 7'd13, 7'd23, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[17] = row_of(mte_pkg::CMD_NOTE_ON, 31'd33022, 7'd14, 7'd24, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[18] = row_of(mte_pkg::CMD_NOTE_OFF, 31'd2130174, 7'd15, 7'd25, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[19] = row_of(mte_pkg::CMD_NOTE_ON, 31'd270565629, 7'd16, 7'd26, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[20] = row_of(mte_pkg::CMD_NOTE_ON, 31'h7FFFFFFF, 7'd17, 7'd27, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[21] = row_of(mte_pkg::CMD_NOTE_OFF, 31'h7FFFFFFF, 7'd18, 7'd28, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[22] = row_of(mte_pkg::CMD_NOTE_OFF, 31'd0, 7'd19, 7'd29, 24'd0,
                          1'b0, 32'd0, 1'b0);
    dir_rows[23] = row_of(mte_pkg::CMD_END, 31'd0, 7'd0, 7'd0, 24'd0,
                          1'b0, 32'd0, 1'b0);

    repeat (7) @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < N_DIR; r++) send_item(dir_rows[r].item, dir_rows[r].chk);

    for (phase = 0; phase < N_PHASES; phase++) begin
      drain_output();
      // Register set for this phase: all low, all high, then random
      case (phase)
        0:       vals = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
        1:       vals = '{24'hFFFF, 24'hFFFFFF, 24'hF, 24'h7F, 24'h7F};
        default: begin
          for (r = 0; r < 5; r++) vals[r] = 24'($urandom);
        end
      endcase
      write_reg(mte_pkg::CFG_DIVISIONS,        vals[0]);
      write_reg(mte_pkg::CFG_TEMPO_US,         vals[1]);
      write_reg(mte_pkg::CFG_CHANNEL,          vals[2]);
      write_reg(mte_pkg::CFG_PROGRAM,          vals[3]);
      write_reg(mte_pkg::CFG_RELEASE_VELOCITY, vals[4]);
      if (phase > 1 && $urandom_range(0, 1))
        write_reg(mte_pkg::CFG_RELEASE_VELOCITY + 3'd1 + 3'($urandom_range(0, 2)),
                  24'($urandom));

      src_free  = (phase == FREE_PHASE);
      sink_free = (phase == FREE_PHASE);
      if (phase == HOLD_PHASE) stall_req = 1'b1;

      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) begin
        if ($urandom_range(0, 99) < 80) play_track();
        else send_item(random_item(), NO_CHECK);
      end
    end

    drain_output();
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
